[design/aacp_pkg.sv]
// ----------------------------------------------------------------------------
// AAC audio config parser package
// Shared sizes, bitstream codes, result layout and the sampling rate table.
// ----------------------------------------------------------------------------
package aacp_pkg;

  localparam int unsigned MAX_RECORD_BYTES = 64;
  localparam int unsigned ADDR_W = $clog2(MAX_RECORD_BYTES);
  localparam int unsigned CNT_W  = $clog2(MAX_RECORD_BYTES + 1);
  localparam int unsigned POS_W  = $clog2(MAX_RECORD_BYTES * 8 + 1);
  localparam int unsigned LEN_W  = 7;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd2;

  localparam logic [4:0]  AOT_ESCAPE   = 5'd31;
  localparam logic [6:0]  AOT_ESC_BASE = 7'd32;
  localparam logic [6:0]  AOT_AAC_LC   = 7'd2;
  localparam logic [6:0]  AOT_SBR      = 7'd5;
  localparam logic [6:0]  AOT_PS       = 7'd22;
  localparam logic [3:0]  SFI_EXPLICIT = 4'd15;
  localparam logic [10:0] SYNC_SBR     = 11'h2b7;
  localparam logic [10:0] SYNC_PS      = 11'h548;
  localparam logic [POS_W-1:0] SYNC_MIN_BITS = POS_W'(16);
  localparam logic [POS_W-1:0] PS_MIN_BITS   = POS_W'(12);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNSUP_AOT = 2'd1,
    ST_CH_ZERO   = 2'd2,
    ST_TRUNC     = 2'd3
  } status_t;

  typedef struct packed {
    status_t     parse_status;
    logic [6:0]  aud_obj_type;
    logic [3:0]  sampling_index;
    logic [23:0] sample_rate_hz;
    logic [3:0]  channel_config;
    logic [3:0]  channel_count;
    logic        frame_length_flag;
    logic        depends_on_core;
    logic [13:0] core_coder_delay;
    logic [6:0]  ext_obj_type;
    logic        sbr_present;
    logic        ps_present;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] total_bits;
    logic             take;
  } seq_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_sts_t;

  function automatic logic [23:0] rate_lookup(input logic [3:0] idx);
    logic [23:0] r;
    case (idx)
      4'd0:    r = 24'd96000;
      4'd1:    r = 24'd88200;
      4'd2:    r = 24'd64000;
      4'd3:    r = 24'd48000;
      4'd4:    r = 24'd44100;
      4'd5:    r = 24'd32000;
      4'd6:    r = 24'd24000;
      4'd7:    r = 24'd22050;
      4'd8:    r = 24'd16000;
      4'd9:    r = 24'd12000;
      4'd10:   r = 24'd11025;
      4'd11:   r = 24'd8000;
      4'd12:   r = 24'd7350;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

endpackage

[design/aacp_if.sv]
// ----------------------------------------------------------------------------
// AAC audio config parser channels
// Valid/ready request channels for record bytes and parse results.
// ----------------------------------------------------------------------------
interface aacp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface aacp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  parse_status;
  logic [6:0]  aud_obj_type;
  logic [3:0]  sampling_index;
  logic [23:0] sample_rate_hz;
  logic [3:0]  channel_config;
  logic [3:0]  channel_count;
  logic        frame_length_flag;
  logic        depends_on_core;
  logic [13:0] core_coder_delay;
  logic [6:0]  ext_obj_type;
  logic        sbr_present;
  logic        ps_present;

  modport source (
    output valid, input ready,
    output parse_status, output aud_obj_type, output sampling_index,
    output sample_rate_hz, output channel_config, output channel_count,
    output frame_length_flag, output depends_on_core, output core_coder_delay,
    output ext_obj_type, output sbr_present, output ps_present
  );
  modport sink (
    input valid, output ready,
    input parse_status, input aud_obj_type, input sampling_index,
    input sample_rate_hz, input channel_config, input channel_count,
    input frame_length_flag, input depends_on_core, input core_coder_delay,
    input ext_obj_type, input sbr_present, input ps_present
  );
endinterface

[design/aac_audio_config_parser_core.sv]
// Record bytes arrive one per request and are stored in a 64 x 8 RAM with one
// write and one read port; each byte is taken as soon as it is offered while
// the decoder is idle. The last byte of a record starts the decode, which reads
// the stored record one bit per cycle while shifting a field, through a single
// shifter/comparator that checks each field against the record length first;
// the result then moves into the output register once that register is free.
// No request is taken while decoding; a result waiting in the output register
// does not hold off the bytes of the next record. Stored bytes need no clearing
// after reset, since a decode reads only bytes written for that record.
// ----------------------------------------------------------------------------
// AAC audio config parser core
// Length register, byte collection, decode sequencer and result register.
// ----------------------------------------------------------------------------
module aac_audio_config_parser_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [aacp_pkg::LEN_W-1:0] cfg_wr_data,
  aacp_in_if.sink                    in_chan,
  aacp_out_if.source                 out_chan
);

  logic [aacp_pkg::LEN_W-1:0] cfg_len_r;
  logic [aacp_pkg::CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [aacp_pkg::CNT_W-1:0] eff_len;
  logic                       in_acc;
  logic                       last_byte;
  logic                       out_valid_r, out_valid_nxt;
  aacp_pkg::result_t          out_res_r;
  aacp_pkg::result_t          seq_res;
  aacp_pkg::seq_ctl_t         seq_ctl;
  aacp_pkg::seq_sts_t         seq_sts;
  logic [aacp_pkg::ADDR_W-1:0] rd_addr;
  logic [7:0]                 rd_data;

  always_comb begin
    if (cfg_len_r == '0) begin
      eff_len = aacp_pkg::CNT_W'(1);
    end else if (int'(cfg_len_r) > aacp_pkg::MAX_RECORD_BYTES) begin
      eff_len = aacp_pkg::CNT_W'(aacp_pkg::MAX_RECORD_BYTES);
    end else begin
      eff_len = aacp_pkg::CNT_W'(cfg_len_r);
    end
  end

  assign in_chan.ready = seq_sts.idle;
  assign in_acc        = in_chan.valid && seq_sts.idle;
  assign last_byte     = ((byte_cnt_r + 1'b1) >= eff_len);

  always_comb begin
    byte_cnt_nxt = byte_cnt_r;
    if (in_acc) begin
      byte_cnt_nxt = last_byte ? '0 : byte_cnt_r + 1'b1;
    end
  end

  assign seq_ctl.start      = in_acc && last_byte;
  assign seq_ctl.total_bits = aacp_pkg::POS_W'({eff_len, 3'b000});
  assign seq_ctl.take       = seq_sts.done && (!out_valid_r || out_chan.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (seq_ctl.take) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r   <= aacp_pkg::LEN_RESET;
      byte_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_len_r <= cfg_wr_data;
      end
      byte_cnt_r  <= byte_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (seq_ctl.take) begin
      out_res_r <= seq_res;
    end
  end

  aacp_byte_store u_store (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (byte_cnt_r[aacp_pkg::ADDR_W-1:0]),
    .wr_data (in_chan.data_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  aacp_field_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (seq_ctl),
    .sts     (seq_sts),
    .result  (seq_res),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_chan.valid                 = out_valid_r;
  assign out_chan.parse_status          = out_res_r.parse_status;
  assign out_chan.aud_obj_type          = out_res_r.aud_obj_type;
  assign out_chan.sampling_index        = out_res_r.sampling_index;
  assign out_chan.sample_rate_hz        = out_res_r.sample_rate_hz;
  assign out_chan.channel_config        = out_res_r.channel_config;
  assign out_chan.channel_count         = out_res_r.channel_count;
  assign out_chan.frame_length_flag     = out_res_r.frame_length_flag;
  assign out_chan.depends_on_core       = out_res_r.depends_on_core;
  assign out_chan.core_coder_delay      = out_res_r.core_coder_delay;
  assign out_chan.ext_obj_type          = out_res_r.ext_obj_type;
  assign out_chan.sbr_present           = out_res_r.sbr_present;
  assign out_chan.ps_present            = out_res_r.ps_present;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r < aacp_pkg::CNT_W'(aacp_pkg::MAX_RECORD_BYTES))
    else $error("byte count past record store");

  a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    seq_ctl.start |=> !in_chan.ready)
    else $error("request taken while decoding");

  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.parse_status == aacp_pkg::ST_OK) |->
      (out_res_r.aud_obj_type == aacp_pkg::AOT_AAC_LC && out_res_r.channel_config != 4'd0))
    else $error("ok status with invalid core fields");

  a_ps_needs_sbr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.ps_present) |->
      (out_res_r.sbr_present && out_res_r.ext_obj_type == aacp_pkg::AOT_SBR))
    else $error("ps flagged without sbr extension");

endmodule

[design/aacp_byte_store.sv]
// ----------------------------------------------------------------------------
// AAC audio config parser record store
// One write port, one registered read port, one byte per entry.
// ----------------------------------------------------------------------------
module aacp_byte_store (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [aacp_pkg::ADDR_W-1:0] wr_addr,
  input  logic [7:0]                wr_data,
  input  logic [aacp_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                rd_data
);

  logic [7:0] mem_r [aacp_pkg::MAX_RECORD_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/aacp_field_seq.sv]
// ----------------------------------------------------------------------------
// AAC audio config parser field sequencer
// Walks the stored record one bit per cycle while shifting a field, through a
// single shift/compare unit, field by field, and builds the result.
// ----------------------------------------------------------------------------
module aacp_field_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  aacp_pkg::seq_ctl_t          ctl,
  output aacp_pkg::seq_sts_t          sts,
  output aacp_pkg::result_t           result,
  output logic [aacp_pkg::ADDR_W-1:0] rd_addr,
  input  logic [7:0]                  rd_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_PRIME, S_CHECK, S_SHIFT, S_DECIDE, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    P_AOT, P_AOT_ESC, P_SFI, P_RATE, P_CHCFG, P_FLEN, P_DEPC, P_DELAY,
    P_EXTF, P_EXT3, P_SYNC, P_EAOT, P_EAOT_ESC, P_SBR, P_ESFI, P_ERATE,
    P_PSSYNC, P_PS, P_ECH
  } phase_t;

  function automatic logic [4:0] field_bits(input phase_t p);
    logic [4:0] n;
    case (p)
      P_AOT, P_EAOT:                     n = 5'd5;
      P_AOT_ESC, P_EAOT_ESC:             n = 5'd6;
      P_SFI, P_CHCFG, P_ESFI, P_ECH:     n = 5'd4;
      P_RATE, P_ERATE:                   n = 5'd24;
      P_DELAY:                           n = 5'd14;
      P_SYNC, P_PSSYNC:                  n = 5'd11;
      default:                           n = 5'd1;
    endcase
    return n;
  endfunction

  state_t                      state_r, state_nxt;
  phase_t                      phase_r, phase_nxt;
  logic [aacp_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [aacp_pkg::POS_W-1:0]  total_r, total_nxt;
  logic [23:0]                 acc_r, acc_nxt;
  logic [4:0]                  left_r, left_nxt;
  aacp_pkg::result_t           res_r, res_nxt;

  logic                        bit_in;
  logic [aacp_pkg::POS_W-1:0]  rem;
  logic [aacp_pkg::POS_W:0]    end_pos;
  logic [6:0]                  ext_aot;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    total_nxt = total_r;
    acc_nxt   = acc_r;
    left_nxt  = left_r;
    res_nxt   = res_r;
    bit_in    = rd_data[~pos_r[2:0]];
    rem       = total_r - pos_r;
    end_pos   = {1'b0, pos_r} + (aacp_pkg::POS_W + 1)'(field_bits(phase_r));
    ext_aot   = {2'b00, acc_r[4:0]};

    case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          state_nxt = S_PRIME;
          phase_nxt = P_AOT;
          pos_nxt   = '0;
          total_nxt = ctl.total_bits;
          res_nxt   = '0;
        end
      end

      // byte 0 may have been written on the start edge: read it again
      S_PRIME: state_nxt = S_CHECK;

      S_CHECK: begin
        if (phase_r == P_SYNC && rem < aacp_pkg::SYNC_MIN_BITS) begin
          res_nxt.parse_status = aacp_pkg::ST_OK;
          state_nxt = S_DONE;
        end else if (phase_r == P_PSSYNC && rem < aacp_pkg::PS_MIN_BITS) begin
          res_nxt.parse_status = aacp_pkg::ST_OK;
          state_nxt = S_DONE;
        end else if (end_pos > {1'b0, total_r}) begin
          res_nxt.parse_status = aacp_pkg::ST_TRUNC;
          state_nxt = S_DONE;
        end else begin
          acc_nxt   = '0;
          left_nxt  = field_bits(phase_r);
          state_nxt = S_SHIFT;
        end
      end

      S_SHIFT: begin
        acc_nxt  = {acc_r[22:0], bit_in};
        pos_nxt  = pos_r + 1'b1;
        left_nxt = left_r - 1'b1;
        if (left_r == 5'd1) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        state_nxt = S_CHECK;
        case (phase_r)
          P_AOT: begin
            if (acc_r[4:0] == aacp_pkg::AOT_ESCAPE) begin
              phase_nxt = P_AOT_ESC;
            end else begin
              res_nxt.aud_obj_type = {2'b00, acc_r[4:0]};
              if ({2'b00, acc_r[4:0]} != aacp_pkg::AOT_AAC_LC) begin
                res_nxt.parse_status = aacp_pkg::ST_UNSUP_AOT;
                state_nxt = S_DONE;
              end else begin
                phase_nxt = P_SFI;
              end
            end
          end
          P_AOT_ESC: begin
            res_nxt.aud_obj_type = aacp_pkg::AOT_ESC_BASE + {1'b0, acc_r[5:0]};
            res_nxt.parse_status = aacp_pkg::ST_UNSUP_AOT;
            state_nxt = S_DONE;
          end
          P_SFI: begin
            res_nxt.sampling_index = acc_r[3:0];
            if (acc_r[3:0] == aacp_pkg::SFI_EXPLICIT) begin
              phase_nxt = P_RATE;
            end else begin
              res_nxt.sample_rate_hz = aacp_pkg::rate_lookup(acc_r[3:0]);
              phase_nxt = P_CHCFG;
            end
          end
          P_RATE: begin
            res_nxt.sample_rate_hz = acc_r;
            phase_nxt = P_CHCFG;
          end
          P_CHCFG: begin
            res_nxt.channel_config = acc_r[3:0];
            case (acc_r[3:0]) inside
              [4'd1:4'd6]: res_nxt.channel_count = acc_r[3:0];
              4'd7:        res_nxt.channel_count = 4'd8;
              default:     res_nxt.channel_count = 4'd0;
            endcase
            if (acc_r[3:0] == 4'd0) begin
              res_nxt.parse_status = aacp_pkg::ST_CH_ZERO;
              state_nxt = S_DONE;
            end else begin
              phase_nxt = P_FLEN;
            end
          end
          P_FLEN: begin
            res_nxt.frame_length_flag = acc_r[0];
            phase_nxt = P_DEPC;
          end
          P_DEPC: begin
            res_nxt.depends_on_core = acc_r[0];
            phase_nxt = acc_r[0] ? P_DELAY : P_EXTF;
          end
          P_DELAY: begin
            res_nxt.core_coder_delay = acc_r[13:0];
            phase_nxt = P_EXTF;
          end
          P_EXTF: phase_nxt = acc_r[0] ? P_EXT3 : P_SYNC;
          P_EXT3: phase_nxt = P_SYNC;
          P_SYNC: begin
            if (acc_r[10:0] == aacp_pkg::SYNC_SBR) begin
              phase_nxt = P_EAOT;
            end else begin
              res_nxt.parse_status = aacp_pkg::ST_OK;
              state_nxt = S_DONE;
            end
          end
          P_EAOT: begin
            if (acc_r[4:0] == aacp_pkg::AOT_ESCAPE) begin
              phase_nxt = P_EAOT_ESC;
            end else begin
              res_nxt.ext_obj_type = ext_aot;
              if (ext_aot == aacp_pkg::AOT_SBR || ext_aot == aacp_pkg::AOT_PS) begin
                phase_nxt = P_SBR;
              end else begin
                res_nxt.parse_status = aacp_pkg::ST_OK;
                state_nxt = S_DONE;
              end
            end
          end
          P_EAOT_ESC: begin
            res_nxt.ext_obj_type =
              aacp_pkg::AOT_ESC_BASE + {1'b0, acc_r[5:0]};
            res_nxt.parse_status = aacp_pkg::ST_OK;
            state_nxt = S_DONE;
          end
          P_SBR: begin
            res_nxt.sbr_present = acc_r[0];
            if (acc_r[0]) begin
              phase_nxt = P_ESFI;
            end else if (res_r.ext_obj_type == aacp_pkg::AOT_PS) begin
              phase_nxt = P_ECH;
            end else begin
              res_nxt.parse_status = aacp_pkg::ST_OK;
              state_nxt = S_DONE;
            end
          end
          P_ESFI, P_ERATE: begin
            if (phase_r == P_ESFI && acc_r[3:0] == aacp_pkg::SFI_EXPLICIT) begin
              phase_nxt = P_ERATE;
            end else if (res_r.ext_obj_type == aacp_pkg::AOT_SBR) begin
              phase_nxt = P_PSSYNC;
            end else begin
              phase_nxt = P_ECH;
            end
          end
          P_PSSYNC: begin
            if (acc_r[10:0] == aacp_pkg::SYNC_PS) begin
              phase_nxt = P_PS;
            end else begin
              res_nxt.parse_status = aacp_pkg::ST_OK;
              state_nxt = S_DONE;
            end
          end
          P_PS: begin
            res_nxt.ps_present   = acc_r[0];
            res_nxt.parse_status = aacp_pkg::ST_OK;
            state_nxt = S_DONE;
          end
          P_ECH: begin
            res_nxt.parse_status = aacp_pkg::ST_OK;
            state_nxt = S_DONE;
          end
          default: begin
            res_nxt.parse_status = aacp_pkg::ST_OK;
            state_nxt = S_DONE;
          end
        endcase
      end

      S_DONE: begin
        if (ctl.take) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= P_AOT;
      pos_r   <= '0;
      left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      left_r  <= left_nxt;
    end
    total_r <= total_nxt;
    acc_r   <= acc_nxt;
    res_r   <= res_nxt;
  end

  assign rd_addr  = pos_nxt[aacp_pkg::ADDR_W+2:3];
  assign sts.idle = (state_r == S_IDLE);
  assign sts.done = (state_r == S_DONE);
  assign result   = res_r;

endmodule

[sim/aacp_record_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AAC audio config record checker
// Watches the byte, result and length ports and rebuilds each record from the
// accepted byte requests. It decodes the record bit by bit at the programmed
// length and compares every field of the block's result against the oldest
// decoded record still awaited.
// ----------------------------------------------------------------------------
module aacp_record_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [aacp_pkg::LEN_W-1:0] cfg_wr_data,
  aacp_in_if                         in_mon,
  aacp_out_if                        out_mon,
  output int                         mismatch_count,
  output int                         awaited_count,
  output int                         results_checked
);
  import aacp_pkg::*;

  localparam logic [23:0] RATE_HZ [16] = '{
    24'd96000, 24'd88200, 24'd64000, 24'd48000, 24'd44100, 24'd32000,
    24'd24000, 24'd22050, 24'd16000, 24'd12000, 24'd11025, 24'd8000,
    24'd7350, 24'd0, 24'd0, 24'd0
  };

  logic [LEN_W-1:0] length_reg;
  logic [7:0]       record_bytes [MAX_RECORD_BYTES];
  int unsigned      bytes_held;
  int unsigned      read_pos;
  int unsigned      read_limit;
  result_t          awaited_q [$];

  function automatic bit take_field(input int unsigned width, output logic [23:0] value);
    int unsigned bit_pos;
    value = '0;
    if (read_pos + width > read_limit) return 1'b0;
    for (int unsigned i = 0; i < width; i++) begin
      bit_pos = read_pos + i;
      value = {value[22:0], record_bytes[6'(bit_pos >> 3)][3'(7 - (bit_pos & 7))]};
    end
    read_pos += width;
    return 1'b1;
  endfunction

  function automatic bit take_obj_type(output logic [6:0] aot);
    logic [23:0] v;
    aot = '0;
    if (!take_field(5, v)) return 1'b0;
    if (v[4:0] == AOT_ESCAPE) begin
      if (!take_field(6, v)) return 1'b0;
      aot = AOT_ESC_BASE + 7'(v[5:0]);
    end else begin
      aot = 7'(v[4:0]);
    end
    return 1'b1;
  endfunction

  // Status defaults to truncated, so any short read simply returns.
  function automatic result_t decode_record(input int unsigned total_bits);
    result_t     r;
    logic [23:0] v;
    logic [6:0]  aot;
    logic [6:0]  ext;
    r = '0;
    r.parse_status = ST_TRUNC;
    read_pos = 0;
    read_limit = total_bits;
    if (!take_obj_type(aot)) return r;
    r.aud_obj_type = aot;
    if (aot != AOT_AAC_LC) begin
      r.parse_status = ST_UNSUP_AOT;
      return r;
    end
    if (!take_field(4, v)) return r;
    r.sampling_index = v[3:0];
    if (v[3:0] == SFI_EXPLICIT) begin
      if (!take_field(24, v)) return r;
      r.sample_rate_hz = v;
    end else begin
      r.sample_rate_hz = RATE_HZ[v[3:0]];
    end
    if (!take_field(4, v)) return r;
    r.channel_config = v[3:0];
    r.channel_count = (v[3:0] == 4'd7) ? 4'd8 : ((v[3:0] <= 4'd6) ? v[3:0] : 4'd0);
    if (v[3:0] == 4'd0) begin
      r.parse_status = ST_CH_ZERO;
      return r;
    end
    if (!take_field(1, v)) return r;
    r.frame_length_flag = v[0];
    if (!take_field(1, v)) return r;
    r.depends_on_core = v[0];
    if (v[0]) begin
      if (!take_field(14, v)) return r;
      r.core_coder_delay = v[13:0];
    end
    if (!take_field(1, v)) return r;
    if (v[0] && !take_field(1, v)) return r;
    r.parse_status = ST_OK;
    if (read_limit - read_pos < 16) return r;
    r.parse_status = ST_TRUNC;
    if (!take_field(11, v)) return r;
    if (v[10:0] != SYNC_SBR) begin
      r.parse_status = ST_OK;
      return r;
    end
    if (!take_obj_type(ext)) return r;
    r.ext_obj_type = ext;
    if (ext == AOT_SBR || ext == AOT_PS) begin
      if (!take_field(1, v)) return r;
      r.sbr_present = v[0];
      if (v[0]) begin
        if (!take_field(4, v)) return r;
        if (v[3:0] == SFI_EXPLICIT && !take_field(24, v)) return r;
        if (ext == AOT_SBR && read_limit - read_pos >= 12) begin
          if (!take_field(11, v)) return r;
          if (v[10:0] == SYNC_PS) begin
            if (!take_field(1, v)) return r;
            r.ps_present = v[0];
          end
        end
      end
      if (ext == AOT_PS && !take_field(4, v)) return r;
    end
    r.parse_status = ST_OK;
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned seen);
    if (want == seen) return;
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch in result %0d: %s expected %0d, got %0d",
               results_checked, field, want, seen);
  endtask

  always @(posedge clk) begin : watch
    result_t     want;
    int unsigned eff_len;
    if (!rst_n) begin
      length_reg = LEN_RESET;
      bytes_held = 0;
      awaited_q.delete();
      mismatch_count = 0;
      results_checked = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result request with no record awaited, status %0d",
                     out_mon.parse_status);
        end else begin
          want = awaited_q.pop_front();
          check_field("parse_status", 32'(want.parse_status), 32'(out_mon.parse_status));
          check_field("aud_obj_type", 32'(want.aud_obj_type), 32'(out_mon.aud_obj_type));
          check_field("sampling_index", 32'(want.sampling_index),
                      32'(out_mon.sampling_index));
          check_field("sample_rate_hz", 32'(want.sample_rate_hz),
                      32'(out_mon.sample_rate_hz));
          check_field("channel_config", 32'(want.channel_config),
                      32'(out_mon.channel_config));
          check_field("channel_count", 32'(want.channel_count), 32'(out_mon.channel_count));
          check_field("frame_length_flag", 32'(want.frame_length_flag),
                      32'(out_mon.frame_length_flag));
          check_field("depends_on_core", 32'(want.depends_on_core),
                      32'(out_mon.depends_on_core));
          check_field("core_coder_delay", 32'(want.core_coder_delay),
                      32'(out_mon.core_coder_delay));
          check_field("ext_obj_type", 32'(want.ext_obj_type),
                      32'(out_mon.ext_obj_type));
          check_field("sbr_present", 32'(want.sbr_present), 32'(out_mon.sbr_present));
          check_field("ps_present", 32'(want.ps_present), 32'(out_mon.ps_present));
        end
        results_checked++;
      end
      if (in_mon.valid && in_mon.ready) begin
        eff_len = (length_reg == '0) ? 1 :
                  ((length_reg > MAX_RECORD_BYTES) ? MAX_RECORD_BYTES : 32'(length_reg));
        if (bytes_held < MAX_RECORD_BYTES)
          record_bytes[6'(bytes_held)] = in_mon.data_byte;
        bytes_held++;
        if (bytes_held >= eff_len) begin
          awaited_q.push_back(decode_record(eff_len * 8));
          bytes_held = 0;
        end
      end
      if (cfg_wr_en) length_reg = cfg_wr_data;
    end
    awaited_count = awaited_q.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AAC audio config parser testbench
// Builds AudioSpecificConfig records bit by bit and feeds them as byte
// requests, first a handful of hand-made cases, then random records under a
// range of programmed lengths. Both channels stall at random; a separate
// checker predicts and compares every parse result.
// ----------------------------------------------------------------------------
module testbench;
  import aacp_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DECODE_TAIL  = 400;
  localparam int RANDOM_BYTES = 1100;
  localparam int PHASE_BYTES  = 75;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  aacp_in_if  in_chan ();
  aacp_out_if out_chan ();

  int mismatch_count;
  int awaited_count;
  int results_checked;

  bit          steady;
  int          cycle_count;
  int          bytes_sent;
  int          settings_used;
  int unsigned put_pos;
  logic [7:0]  rec_mem [MAX_RECORD_BYTES];

  aac_audio_config_parser_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .out_chan    (out_chan)
  );

  aacp_record_checker record_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .mismatch_count  (mismatch_count),
    .awaited_count   (awaited_count),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= steady || ($urandom_range(0, 99) >= 16);
    end
  end

  function automatic int unsigned record_bytes_for(input logic [LEN_W-1:0] len);
    if (len == '0) return 1;
    if (len > MAX_RECORD_BYTES) return MAX_RECORD_BYTES;
    return 32'(len);
  endfunction

  // Random fill first, so anything past the written fields is noise.
  function automatic void start_record();
    foreach (rec_mem[i]) rec_mem[i] = 8'($urandom);
    put_pos = 0;
  endfunction

  function automatic void put_bits(input int unsigned width, input logic [23:0] value);
    for (int unsigned i = 0; i < width; i++) begin
      rec_mem[6'(put_pos >> 3)][3'(7 - (put_pos & 7))] = value[5'(width - 1 - i)];
      put_pos++;
    end
  endfunction

  task automatic send_byte(input logic [7:0] data);
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data_byte <= data;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_record(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_byte(rec_mem[i]);
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (awaited_count != 0) @(negedge clk);
    repeat (DECODE_TAIL) @(negedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    cfg_wr_data <= len;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic put_rate_index();
    logic [3:0] sfi;
    sfi = ($urandom_range(0, 7) == 0) ? SFI_EXPLICIT : 4'($urandom);
    put_bits(4, 24'(sfi));
    if (sfi == SFI_EXPLICIT) put_bits(24, 24'($urandom));
  endtask

  // Mostly well-formed AAC-LC records, some with SBR/PS extensions,
  // the rest wrong object types or plain noise.
  task automatic compose_random_record();
    int unsigned pick;
    logic [4:0]  aot5;
    logic [6:0]  ext;
    bit          flag;
    start_record();
    pick = $urandom_range(0, 99);
    if (pick < 8) return;
    if (pick < 18) begin
      aot5 = 5'($urandom);
      if (aot5 == 5'(AOT_AAC_LC)) aot5 = AOT_ESCAPE;
      put_bits(5, 24'(aot5));
      if (aot5 == AOT_ESCAPE) put_bits(6, 24'($urandom));
      return;
    end
    put_bits(5, 24'(AOT_AAC_LC));
    put_rate_index();
    put_bits(4, ($urandom_range(0, 9) == 0) ? 24'd0 : 24'($urandom_range(1, 15)));
    put_bits(1, 24'($urandom));
    flag = 1'($urandom);
    put_bits(1, 24'(flag));
    if (flag) put_bits(14, 24'($urandom));
    flag = 1'($urandom);
    put_bits(1, 24'(flag));
    if (flag) put_bits(1, 24'($urandom));
    if ($urandom_range(0, 3) == 0) return;
    put_bits(11, ($urandom_range(0, 5) == 0) ? 24'($urandom) : 24'(SYNC_SBR));
    pick = $urandom_range(0, 9);
    ext = (pick < 4) ? AOT_SBR : ((pick < 7) ? AOT_PS : 7'($urandom_range(0, 95)));
    if (ext >= AOT_ESC_BASE) begin
      put_bits(5, 24'(AOT_ESCAPE));
      put_bits(6, 24'(ext - AOT_ESC_BASE));
    end else begin
      put_bits(5, 24'(ext));
    end
    if (ext != AOT_SBR && ext != AOT_PS) return;
    flag = ($urandom_range(0, 3) != 0);
    put_bits(1, 24'(flag));
    if (flag) begin
      put_rate_index();
      if (ext == AOT_SBR) begin
        put_bits(11, ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'(SYNC_PS));
        put_bits(1, 24'($urandom));
      end
    end
    if (ext == AOT_PS) put_bits(4, 24'($urandom));
  endtask

  initial begin : stimulus
    logic [LEN_W-1:0] phase_len [16];
    logic [LEN_W-1:0] len;
    int               phase;
    int               random_bytes;
    int               phase_bytes;
    phase_len = '{7'd3, 7'd5, 7'd1, 7'd8, 7'd2, 7'd127, 7'd6, 7'd4,
                  7'd12, 7'd64, 7'd9, 7'd16, 7'd65, 7'd7, 7'd0, 7'd10};
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_chan.valid = 1'b0;
    in_chan.data_byte = '0;
    steady = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // two-byte records at the reset length
    start_record();
    put_bits(5, 24'(AOT_AAC_LC));
    put_bits(4, 24'd4);
    put_bits(4, 24'd2);
    put_bits(3, 24'd0);
    send_record(2);
    start_record();
    put_bits(16, 24'h0000);
    send_record(2);
    start_record();
    put_bits(16, 24'hFFFF);
    send_record(2);
    start_record();
    put_bits(5, 24'(AOT_ESCAPE));
    put_bits(6, 24'd0);
    send_record(2);
    start_record();
    put_bits(5, 24'(AOT_AAC_LC));
    put_bits(4, 24'd3);
    put_bits(4, 24'd0);
    send_record(2);
    start_record();
    put_bits(5, 24'(AOT_AAC_LC));
    put_bits(4, 24'(SFI_EXPLICIT));
    send_record(2);
    settle();

    // length zero acts as one byte
    write_length('0);
    start_record();
    put_bits(5, 24'(AOT_AAC_LC));
    send_record(1);
    start_record();
    put_bits(8, 24'hFF);
    send_record(1);
    settle();

    // SBR sync extension carrying PS
    write_length(7'd7);
    start_record();
    put_bits(5, 24'(AOT_AAC_LC));
    put_bits(4, 24'd6);
    put_bits(4, 24'd2);
    put_bits(3, 24'd0);
    put_bits(11, 24'(SYNC_SBR));
    put_bits(5, 24'(AOT_SBR));
    put_bits(1, 24'd1);
    put_bits(4, 24'd3);
    put_bits(11, 24'(SYNC_PS));
    put_bits(1, 24'd1);
    send_record(7);
    settle();

    // length cut below the bytes already held ends the record on the next byte
    write_length(7'd5);
    start_record();
    put_bits(5, 24'(AOT_AAC_LC));
    put_bits(4, 24'd0);
    put_bits(4, 24'd7);
    put_bits(3, 24'd0);
    send_record(3);
    settle();
    write_length(7'd2);
    send_byte(8'($urandom));
    settle();

    phase = 0;
    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      len = (phase < 16) ? phase_len[phase] : 7'($urandom_range(1, 16));
      steady = (phase == 2 || phase == 3);
      write_length(len);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        compose_random_record();
        send_record(record_bytes_for(len));
        phase_bytes += record_bytes_for(len);
      end
      settle();
      random_bytes += phase_bytes;
      phase++;
    end
    steady = 1'b0;
    settle();

    $display("%0d record bytes sent under %0d length settings (escape, explicit rate,",
             bytes_sent, settings_used);
    $display("  truncation, SBR/PS and mid-record length change); %0d results compared",
             results_checked);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
